FILE: sv/ray_disk_intersect_defines.svh
// assertion macros for the ray disk intersection block
`ifndef RAY_DISK_INTERSECT_DEFINES_SVH
`define RAY_DISK_INTERSECT_DEFINES_SVH

// same-cycle implication, sampled on clk, quiet during rst
`define RDI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, also checked while rst is high
`define RDI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/rdi_pkg.sv
// shared constants and word types for the ray disk intersection block
package rdi_pkg;

  localparam int CW = 32;  // coordinate width
  localparam int FB = 16;  // fraction bits
  localparam int RADW = CW - 1;
  localparam int CFG_IDX_W = 3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_Z = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS   = 3'd6;

  typedef struct packed {
    logic signed [CW-1:0] origin_x;
    logic signed [CW-1:0] origin_y;
    logic signed [CW-1:0] origin_z;
    logic signed [CW-1:0] dir_x;
    logic signed [CW-1:0] dir_y;
    logic signed [CW-1:0] dir_z;
    logic signed [CW-1:0] near_limit;
    logic signed [CW-1:0] far_limit;
  } ray_t;

  typedef struct packed {
    logic                 hit;
    logic signed [CW-1:0] distance;
  } res_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [CW-1:0]        data;
  } cfg_t;

endpackage

FILE: sv/rdi_if.sv
// valid/ready channel interfaces for rays, results and register writes
interface rdi_ray_if import rdi_pkg::*; ();
  logic valid;
  logic ready;
  ray_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rdi_res_if import rdi_pkg::*; ();
  logic valid;
  logic ready;
  res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rdi_cfg_if import rdi_pkg::*; ();
  logic valid;
  logic ready;
  cfg_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: sv/ray_disk_intersect.sv
// ray against configured disk intersection test, fully pipelined
//
//  channel   dir  word
//  rays      in   origin, direction, near and far limits
//  results   out  hit flag and distance t
//  cfg       in   register index and data
//
// one ray per cycle while results is not stalled; the restoring divider takes
// one quotient bit per stage, with the dot product, saturation and squared
// distance stages around it.
// rst clears the valid bits and reloads the register reset values.
// when results stalls the whole pipeline holds; cfg is always ready.
`include "ray_disk_intersect_defines.svh"

module ray_disk_intersect import rdi_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  rdi_ray_if.sink       rays,
  rdi_res_if.source     results,
  rdi_cfg_if.sink       cfg
);

  localparam int PW  = 2 * CW;          // product
  localparam int DW  = 2 * CW + 2;      // dot product sum
  localparam int NW  = DW + 1 + FB;     // scaled numerator
  localparam int RW  = DW + CW;         // divider remainder
  localparam int EW  = 2 * CW + 2;      // hit offset, signed
  localparam int AW  = 2 * CW + 1;      // hit offset magnitude
  localparam int LOW = CW + 1;          // low part of split offset
  localparam int HIW = AW - LOW;        // high part
  localparam int SW  = 2 * AW;          // squared offset
  localparam int QW  = SW + 2;          // sum of three squares
  localparam int RRW = 2 * RADW;
  localparam int NST = CW + 10;         // stage count

  localparam logic signed [CW-1:0] T_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] T_MIN = {1'b1, {(CW-1){1'b0}}};

  typedef struct packed {
    logic signed [CW:0]   dfx, dfy, dfz;
    logic signed [CW-1:0] dx, dy, dz, near, far;
  } ray_side_t;

  typedef struct packed {
    logic signed [PW-1:0] ndx, ndy, ndz, ncx, ncy, ncz, nox, noy, noz;
    ray_side_t            rs;
  } sa_t;

  typedef struct packed {
    logic signed [DW-1:0] dn;
    logic signed [NW-1:0] num;
    ray_side_t            rs;
  } sb_t;

  typedef struct packed {
    logic [DW-1:0] den;
    logic [RW-1:0] rem;
    logic [CW-1:0] q;
    logic          neg, zero, ovf;
    ray_side_t     rs;
  } div_t;

  typedef struct packed {
    logic signed [CW-1:0] t;
    logic                 zero;
    ray_side_t            rs;
  } st_t;

  typedef struct packed {
    logic signed [PW-1:0] qx, qy, qz;
    logic [RRW-1:0]       rr;
    logic signed [CW-1:0] t;
    logic                 zero;
    ray_side_t            rs;
  } sm_t;

  typedef struct packed {
    logic [AW-1:0]        ax, ay, az;
    logic [RRW-1:0]       rr;
    logic signed [CW-1:0] t;
    logic                 zero, inlim;
  } se_t;

  typedef struct packed {
    logic [2*HIW-1:0]     hhx, hhy, hhz;
    logic [HIW+LOW-1:0]   hlx, hly, hlz;
    logic [2*LOW-1:0]     llx, lly, llz;
    logic [RRW-1:0]       rr;
    logic signed [CW-1:0] t;
    logic                 zero, inlim;
  } sp_t;

  typedef struct packed {
    logic [SW-1:0]        sx, sy, sz;
    logic [RRW-1:0]       rr;
    logic signed [CW-1:0] t;
    logic                 zero, inlim;
  } ss_t;

  // configuration registers
  logic signed [CW-1:0] center_x, center_y, center_z;
  logic signed [CW-1:0] normal_x, normal_y, normal_z;
  logic [RADW-1:0]      radius;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x <= '0;
      center_y <= '0;
      center_z <= '0;
      normal_x <= '0;
      normal_y <= '0;
      normal_z <= CW'(1) <<< FB;
      radius   <= RADW'(1) << FB;
    end else if (cfg.valid) begin
      case (cfg.data.index)
        REG_CENTER_X: center_x <= cfg.data.data;
        REG_CENTER_Y: center_y <= cfg.data.data;
        REG_CENTER_Z: center_z <= cfg.data.data;
        REG_NORMAL_X: normal_x <= cfg.data.data;
        REG_NORMAL_Y: normal_y <= cfg.data.data;
        REG_NORMAL_Z: normal_z <= cfg.data.data;
        REG_RADIUS:   radius   <= cfg.data.data[RADW-1:0];
        default: ;
      endcase
    end
  end

  // global advance: the pipeline moves unless the output word is stuck
  logic           en;
  logic [NST-1:0] vld;

  assign en         = !vld[NST-1] || results.ready;
  assign rays.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NST-2:0], rays.valid};
    end
  end

  // stage a: nine products for the dot products, origin minus center
  sa_t sa, sa_next;
  always_comb begin
    sa_next.ndx = normal_x * rays.data.dir_x;
    sa_next.ndy = normal_y * rays.data.dir_y;
    sa_next.ndz = normal_z * rays.data.dir_z;
    sa_next.ncx = normal_x * center_x;
    sa_next.ncy = normal_y * center_y;
    sa_next.ncz = normal_z * center_z;
    sa_next.nox = normal_x * rays.data.origin_x;
    sa_next.noy = normal_y * rays.data.origin_y;
    sa_next.noz = normal_z * rays.data.origin_z;
    sa_next.rs.dfx = (CW+1)'(rays.data.origin_x) - (CW+1)'(center_x);
    sa_next.rs.dfy = (CW+1)'(rays.data.origin_y) - (CW+1)'(center_y);
    sa_next.rs.dfz = (CW+1)'(rays.data.origin_z) - (CW+1)'(center_z);
    sa_next.rs.dx   = rays.data.dir_x;
    sa_next.rs.dy   = rays.data.dir_y;
    sa_next.rs.dz   = rays.data.dir_z;
    sa_next.rs.near = rays.data.near_limit;
    sa_next.rs.far  = rays.data.far_limit;
  end

  // stage b: dot product sums and scaled numerator
  sb_t sb, sb_next;
  logic signed [DW-1:0] nc_sum, no_sum;
  always_comb begin
    nc_sum = DW'(sa.ncx) + DW'(sa.ncy) + DW'(sa.ncz);
    no_sum = DW'(sa.nox) + DW'(sa.noy) + DW'(sa.noz);
    sb_next.dn  = DW'(sa.ndx) + DW'(sa.ndy) + DW'(sa.ndz);
    sb_next.num = (NW'(nc_sum) - NW'(no_sum)) <<< FB;
    sb_next.rs  = sa.rs;
  end

  // stage c: magnitudes and quotient sign
  div_t dv [CW+1];
  div_t dc_next;
  always_comb begin
    dc_next.den  = sb.dn[DW-1] ? DW'(-sb.dn) : DW'(sb.dn);
    dc_next.rem  = RW'(sb.num[NW-1] ? NW'(-sb.num) : NW'(sb.num));
    dc_next.q    = '0;
    dc_next.neg  = sb.num[NW-1] ^ sb.dn[DW-1];
    dc_next.zero = (sb.dn == '0);
    dc_next.ovf  = 1'b0;
    dc_next.rs   = sb.rs;
  end

  div_t dc;
  always_ff @(posedge clk) begin
    if (en) begin
      sa <= sa_next;
      sb <= sb_next;
      dc <= dc_next;
    end
  end

  // divider: first stage flags a quotient of 2^CW or more, then one bit a stage
  div_t d0_next;
  always_comb begin
    d0_next     = dc;
    d0_next.ovf = dc.rem >= ({{CW{1'b0}}, dc.den} << CW);
  end

  always_ff @(posedge clk) begin
    if (en) dv[0] <= d0_next;
  end

  for (genvar j = 1; j <= CW; j++) begin : g_div
    localparam int I = CW - j;
    div_t          dn_next;
    logic [RW-1:0] sh;
    always_comb begin
      dn_next = dv[j-1];
      sh      = {{CW{1'b0}}, dv[j-1].den} << I;
      if (dv[j-1].rem >= sh) begin
        dn_next.rem  = dv[j-1].rem - sh;
        dn_next.q[I] = 1'b1;
      end
    end
    always_ff @(posedge clk) begin
      if (en) dv[j] <= dn_next;
    end
  end

  // stage t: sign and saturation of t
  st_t st, st_next;
  div_t dq;
  always_comb begin
    dq = dv[CW];
    if (dq.neg) begin
      st_next.t = (dq.ovf || (dq.q[CW-1] && |dq.q[CW-2:0])) ? T_MIN : -$signed(dq.q);
    end else begin
      st_next.t = (dq.ovf || dq.q[CW-1]) ? T_MAX : $signed(dq.q);
    end
    st_next.zero = dq.zero;
    st_next.rs   = dq.rs;
  end

  // stage m: t times direction, radius squared
  sm_t sm, sm_next;
  always_comb begin
    sm_next.qx   = st.t * st.rs.dx;
    sm_next.qy   = st.t * st.rs.dy;
    sm_next.qz   = st.t * st.rs.dz;
    sm_next.rr   = RRW'(radius) * RRW'(radius);
    sm_next.t    = st.t;
    sm_next.zero = st.zero;
    sm_next.rs   = st.rs;
  end

  // stage e: offset of hit point from center, magnitudes; limit test
  se_t se, se_next;
  logic signed [EW-1:0] ex, ey, ez;
  always_comb begin
    ex = (EW'(sm.rs.dfx) <<< FB) + EW'(sm.qx);
    ey = (EW'(sm.rs.dfy) <<< FB) + EW'(sm.qy);
    ez = (EW'(sm.rs.dfz) <<< FB) + EW'(sm.qz);
    se_next.ax    = ex[EW-1] ? AW'(-ex) : AW'(ex);
    se_next.ay    = ey[EW-1] ? AW'(-ey) : AW'(ey);
    se_next.az    = ez[EW-1] ? AW'(-ez) : AW'(ez);
    se_next.rr    = sm.rr;
    se_next.t     = sm.t;
    se_next.zero  = sm.zero;
    se_next.inlim = (sm.rs.near <= sm.t) && (sm.t < sm.rs.far);
  end

  // stage p: split squares into partial products
  sp_t sp, sp_next;
  always_comb begin
    sp_next.hhx = se.ax[AW-1:LOW] * se.ax[AW-1:LOW];
    sp_next.hhy = se.ay[AW-1:LOW] * se.ay[AW-1:LOW];
    sp_next.hhz = se.az[AW-1:LOW] * se.az[AW-1:LOW];
    sp_next.hlx = (HIW+LOW)'(se.ax[AW-1:LOW]) * (HIW+LOW)'(se.ax[LOW-1:0]);
    sp_next.hly = (HIW+LOW)'(se.ay[AW-1:LOW]) * (HIW+LOW)'(se.ay[LOW-1:0]);
    sp_next.hlz = (HIW+LOW)'(se.az[AW-1:LOW]) * (HIW+LOW)'(se.az[LOW-1:0]);
    sp_next.llx = (2*LOW)'(se.ax[LOW-1:0]) * (2*LOW)'(se.ax[LOW-1:0]);
    sp_next.lly = (2*LOW)'(se.ay[LOW-1:0]) * (2*LOW)'(se.ay[LOW-1:0]);
    sp_next.llz = (2*LOW)'(se.az[LOW-1:0]) * (2*LOW)'(se.az[LOW-1:0]);
    sp_next.rr    = se.rr;
    sp_next.t     = se.t;
    sp_next.zero  = se.zero;
    sp_next.inlim = se.inlim;
  end

  // stage s: recombine partial products per axis
  ss_t ss, ss_next;
  always_comb begin
    ss_next.sx = (SW'(sp.hhx) << (2*LOW)) + (SW'(sp.hlx) << (LOW+1)) + SW'(sp.llx);
    ss_next.sy = (SW'(sp.hhy) << (2*LOW)) + (SW'(sp.hly) << (LOW+1)) + SW'(sp.lly);
    ss_next.sz = (SW'(sp.hhz) << (2*LOW)) + (SW'(sp.hlz) << (LOW+1)) + SW'(sp.llz);
    ss_next.rr    = sp.rr;
    ss_next.t     = sp.t;
    ss_next.zero  = sp.zero;
    ss_next.inlim = sp.inlim;
  end

  // stage f: radius compare and output word
  res_t          res, res_next;
  logic [QW-1:0] dist2;
  logic          in_disk;
  always_comb begin
    dist2         = QW'(ss.sx) + QW'(ss.sy) + QW'(ss.sz);
    in_disk       = dist2 <= (QW'(ss.rr) << (2*FB));
    res_next.hit  = !ss.zero && in_disk && ss.inlim;
    res_next.distance = res_next.hit ? ss.t : '0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st  <= st_next;
      sm  <= sm_next;
      se  <= se_next;
      sp  <= sp_next;
      ss  <= ss_next;
      res <= res_next;
    end
  end

  assign results.valid = vld[NST-1];
  assign results.data  = res;

  // checks
  `RDI_ASSERT_NOW(a_miss_zero, results.valid && !results.data.hit,
    results.data.distance == '0, "miss word carries a nonzero distance")
  `RDI_ASSERT_NOW(a_ready_rule, results.valid && !results.ready,
    !rays.ready, "ray taken while output word is stalled")
  `RDI_ASSERT_NEXT(a_reset_empty, rst, !results.valid,
    "output word valid right after reset")

endmodule

FILE: verif/testbench.sv
// self-checking testbench for the ray disk intersection block
module testbench;
  import rdi_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [191:0] wide_t;

  logic clk;
  logic rst;
  rdi_ray_if ray_ch ();
  rdi_res_if res_ch ();
  rdi_cfg_if cfg_ch ();

  ray_disk_intersect u_dut (
    .clk     (clk),
    .rst     (rst),
    .rays    (ray_ch),
    .results (res_ch),
    .cfg     (cfg_ch)
  );

  // local copy of the disk registers
  logic signed [CW-1:0] disk_cx, disk_cy, disk_cz;
  logic signed [CW-1:0] disk_nx, disk_ny, disk_nz;
  logic [RADW-1:0]      disk_rad;

  res_t pending_hits[$];
  int   err_count;
  int   res_stall;
  bit   calm;

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // watchdog
  initial begin
    #5ms;
    $display("simulation failed");
    $finish;
  end

  // gap length: mostly none or short, a few long
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // exact intersection of one ray with the current disk
  function automatic res_t intersect_disk(ray_t r);
    wide_t o[3], d[3], n[3], c[3];
    wide_t dn, num, q, e, dist2, rr, lim, nearv, farv;
    wide_t tmax, tmin;
    res_t res;
    res = '0;
    tmax = 64'sd2147483647;
    tmin = -64'sd2147483648;
    o[0] = $signed(r.origin_x); o[1] = $signed(r.origin_y); o[2] = $signed(r.origin_z);
    d[0] = $signed(r.dir_x);    d[1] = $signed(r.dir_y);    d[2] = $signed(r.dir_z);
    n[0] = disk_nx; n[1] = disk_ny; n[2] = disk_nz;
    c[0] = disk_cx; c[1] = disk_cy; c[2] = disk_cz;
    dn = n[0] * d[0] + n[1] * d[1] + n[2] * d[2];
    // parallel ray never hits
    if (dn == 0) return res;
    num = ((n[0] * c[0] + n[1] * c[1] + n[2] * c[2])
         - (n[0] * o[0] + n[1] * o[1] + n[2] * o[2])) <<< FB;
    q = num / dn;  // truncates toward zero
    if (q > tmax) q = tmax;
    if (q < tmin) q = tmin;
    // squared offset of the hit point from the center
    dist2 = 0;
    for (int k = 0; k < 3; k++) begin
      e = ((o[k] - c[k]) <<< FB) + q * d[k];
      dist2 = dist2 + e * e;
    end
    rr = $signed({1'b0, disk_rad});
    lim = (rr * rr) <<< (2 * FB);
    if (dist2 > lim) return res;
    nearv = $signed(r.near_limit);
    farv = $signed(r.far_limit);
    if (nearv <= q && q < farv) begin
      res.hit = 1'b1;
      res.distance = q[CW-1:0];
    end
    return res;
  endfunction

  // send one ray word and queue its expected result
  task automatic send_ray(ray_t r);
    int gap;
    ray_ch.valid <= 1'b1;
    ray_ch.data <= r;
    @(posedge clk);
    while (!ray_ch.ready) @(posedge clk);
    pending_hits.push_back(intersect_disk(r));
    gap = pick_gap();
    if (gap > 0) begin
      ray_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // let the pipeline empty out
  task automatic drain();
    ray_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_hits.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  // register write, only while idle; the caller drops valid after the last one
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CW-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= '{index: idx, data: val};
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      REG_CENTER_X: disk_cx = val;
      REG_CENTER_Y: disk_cy = val;
      REG_CENTER_Z: disk_cz = val;
      REG_NORMAL_X: disk_nx = val;
      REG_NORMAL_Y: disk_ny = val;
      REG_NORMAL_Z: disk_nz = val;
      REG_RADIUS:   disk_rad = val[RADW-1:0];
      default: ;
    endcase
  endtask

  task automatic write_disk(logic [CW-1:0] cx, logic [CW-1:0] cy, logic [CW-1:0] cz,
                            logic [CW-1:0] nx, logic [CW-1:0] ny, logic [CW-1:0] nz,
                            logic [CW-1:0] rad);
    write_reg(REG_CENTER_X, cx);
    write_reg(REG_CENTER_Y, cy);
    write_reg(REG_CENTER_Z, cz);
    write_reg(REG_NORMAL_X, nx);
    write_reg(REG_NORMAL_Y, ny);
    write_reg(REG_NORMAL_Z, nz);
    write_reg(REG_RADIUS, rad);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic ray_t make_ray(int ox, int oy, int oz, int dx, int dy, int dz,
                                    int tn, int tf);
    ray_t r;
    r.origin_x = ox; r.origin_y = oy; r.origin_z = oz;
    r.dir_x = dx;    r.dir_y = dy;    r.dir_z = dz;
    r.near_limit = tn; r.far_limit = tf;
    return r;
  endfunction

  // ray passing near the disk center with random content
  function automatic ray_t aimed_ray();
    ray_t r;
    longint span, px, py, pz, dx, dy, dz, t;
    span = longint'(disk_rad) + 1;
    if (span > 64'd1 << 24) span = 64'd1 << 24;
    px = longint'(disk_cx) + $urandom_range(0, 2 * span) - span;
    py = longint'(disk_cy) + $urandom_range(0, 2 * span) - span;
    pz = longint'(disk_cz) + $urandom_range(0, 2 * span) - span;
    dx = longint'($urandom_range(0, 1 << 19)) - (1 << 18);
    dy = longint'($urandom_range(0, 1 << 19)) - (1 << 18);
    dz = longint'($urandom_range(0, 1 << 19)) - (1 << 18);
    t = $urandom_range(0, 1 << 21);
    r.origin_x = CW'(px - ((t * dx) >>> FB));
    r.origin_y = CW'(py - ((t * dy) >>> FB));
    r.origin_z = CW'(pz - ((t * dz) >>> FB));
    r.dir_x = CW'(dx); r.dir_y = CW'(dy); r.dir_z = CW'(dz);
    case ($urandom_range(0, 5))
      0: begin r.near_limit = $urandom; r.far_limit = $urandom; end
      1: begin r.near_limit = CW'(t + 1); r.far_limit = CW'(t - 1); end
      default: begin
        r.near_limit = CW'(t - longint'($urandom_range(0, 1 << 18)));
        r.far_limit = CW'(t + longint'($urandom_range(1, 1 << 18)));
      end
    endcase
    return r;
  endfunction

  function automatic ray_t noise_ray();
    ray_t r;
    r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    return r;
  endfunction

  // result checker
  always @(posedge clk) begin
    res_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (pending_hits.size() == 0) begin
        $display("%0t: unexpected result hit=%0b distance=%0d", $realtime,
                 res_ch.data.hit, res_ch.data.distance);
        err_count++;
      end else begin
        want = pending_hits.pop_front();
        if (res_ch.data.hit !== want.hit) begin
          $display("%0t: hit expected %0b actual %0b", $realtime, want.hit, res_ch.data.hit);
          err_count++;
        end
        if (res_ch.data.distance !== want.distance) begin
          $display("%0t: distance expected %0d actual %0d", $realtime, want.distance,
                   res_ch.data.distance);
          err_count++;
        end
      end
    end
  end

  // result stall generator
  always @(posedge clk) begin
    if (res_stall > 0) begin
      res_stall--;
      res_ch.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      res_stall = pick_gap();
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= 1'b1;
    end
  end

  // default disk: unit disk at origin in the z = 0 plane
  task automatic test_default_disk();
    send_ray(make_ray(0, 0, -65536, 0, 0, 65536, 0, 32'h7fffffff));
    // point exactly on the rim counts as inside
    send_ray(make_ray(65536, 0, -65536, 0, 0, 65536, 0, 32'h7fffffff));
    send_ray(make_ray(65537, 0, -65536, 0, 0, 65536, 0, 32'h7fffffff));
    // near limit inclusive, far limit exclusive
    send_ray(make_ray(0, 0, -65536, 0, 0, 65536, 65536, 65537));
    send_ray(make_ray(0, 0, -65536, 0, 0, 65536, 0, 65536));
    // empty and inverted limits
    send_ray(make_ray(0, 0, -65536, 0, 0, 65536, 65536, 65536));
    send_ray(make_ray(0, 0, -65536, 0, 0, 65536, 70000, 100));
    // parallel: zero direction, direction in the plane
    send_ray(make_ray(0, 0, -65536, 0, 0, 0, 32'h80000000, 32'h7fffffff));
    send_ray(make_ray(0, 0, 0, 65536, 65536, 0, 32'h80000000, 32'h7fffffff));
    // quotient truncated toward zero
    send_ray(make_ray(0, 0, -65536, 0, 0, 3, 32'h80000000, 32'h7fffffff));
    send_ray(make_ray(0, 0, 65536, 0, 0, 3, 32'h80000000, 32'h7fffffff));
    // saturation both ways
    send_ray(make_ray(0, 0, 32'h80000000, 0, 0, 1, 32'h80000000, 32'h7fffffff));
    send_ray(make_ray(0, 0, 32'h80000000, 0, 0, -1, 32'h80000000, 32'h7fffffff));
    // field extremes
    send_ray(make_ray(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                      32'h7fffffff, 32'h80000000, 32'h7fffffff));
    send_ray(make_ray(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                      32'h80000000, 32'h80000000, 32'h7fffffff));
    send_ray(make_ray(-1, -1, -1, -1, -1, -1, -1, 0));
    drain();
  endtask

  // zero normal makes every ray parallel
  task automatic test_zero_normal();
    write_disk(0, 0, 0, 0, 0, 0, 65536);
    send_ray(make_ray(0, 0, -65536, 0, 0, 65536, 0, 32'h7fffffff));
    send_ray(noise_ray());
    drain();
  endtask

  // streams of aimed rays with some noise mixed in
  task automatic run_rays(int count);
    for (int i = 0; i < count; i++)
      send_ray(($urandom_range(0, 4) == 0) ? noise_ray() : aimed_ray());
    drain();
  endtask

  task automatic test_random_disks();
    int rad;
    // moderate tilted disk
    rad = $urandom_range(1 << 14, 1 << 20);
    write_disk($urandom_range(0, 1 << 22) - (1 << 21), $urandom_range(0, 1 << 22) - (1 << 21),
               $urandom_range(0, 1 << 22) - (1 << 21), $urandom_range(0, 1 << 17) - (1 << 16),
               $urandom_range(0, 1 << 17) - (1 << 16), $urandom_range(0, 1 << 17) - (1 << 16),
               rad);
    run_rays(60);
    // back-to-back traffic with no idling on either side
    calm = 1'b1;
    run_rays(50);
    calm = 1'b0;
    // register extremes
    write_disk(32'h7fffffff, 32'h80000000, 0, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
               32'h7fffffff);
    run_rays(40);
    write_disk(32'h80000000, 32'h7fffffff, 32'h80000000, 32'h80000000, 0, 1, 32'h7fffffff);
    run_rays(30);
    // zero radius
    write_disk(0, 0, 0, 0, 65536, 0, 0);
    run_rays(30);
    // fully random registers
    for (int p = 0; p < 4; p++) begin
      write_disk($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      run_rays(25);
    end
  endtask

  // sender holds off until the pipeline is empty, then resumes
  task automatic test_hold_off();
    write_disk(65536, -65536, 131072, 0, 65536, 65536, 1 << 18);
    for (int i = 0; i < 60; i++) begin
      send_ray(aimed_ray());
      if (i == 30) drain();
    end
    drain();
  endtask

  initial begin
    rst = 1'b1;
    calm = 1'b0;
    err_count = 0;
    res_stall = 0;
    ray_ch.valid = 1'b0;
    ray_ch.data = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    res_ch.ready = 1'b0;
    disk_cx = 0; disk_cy = 0; disk_cz = 0;
    disk_nx = 0; disk_ny = 0; disk_nz = 65536;
    disk_rad = 65536;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_default_disk();
    test_zero_normal();
    test_random_disks();
    test_hold_off();

    if (err_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
